### rtl/core/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on a clock, disabled while reset is high
`define TTE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("tap tempo check failed");

// same, with a caller-supplied message
`define TTE_ASSERT_MSG(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

`endif

### rtl/core/tte_pkg.sv
// tap tempo estimator package: sizes, register indexes, constants
`timescale 1ns / 1ps

package tte_pkg;

   // ring size and timestamp width
   localparam int MAX_TAPS  = 8;
   localparam int TIME_BITS = 40;

   // derived sizes
   localparam int SLOT_W  = $clog2(MAX_TAPS);
   localparam int CNT_W   = $clog2(MAX_TAPS + 1);
   localparam int IVL_W   = 24;
   localparam int SUM_W   = IVL_W + $clog2(MAX_TAPS);
   localparam int NUMER_W = 30;
   localparam int QUO_W   = NUMER_W + CNT_W;
   localparam int STEP_W  = $clog2(QUO_W + 1);
   localparam int TEMPO_W = 14;
   localparam int USED_W  = 3;

   // tenths of bpm per microsecond interval
   localparam logic [NUMER_W-1:0] TENTHS_NUMERATOR = NUMER_W'(600000000);
   localparam logic [USED_W-1:0]  USED_MAX         = '1;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_RESTART_GAP  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_INTERVAL = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_INTERVAL = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BPM_FLOOR    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BPM_CEILING  = 3'd4;

   // reset values
   localparam logic [IVL_W-1:0]   RESTART_GAP_RST  = 24'd2000000;
   localparam logic [IVL_W-1:0]   MIN_INTERVAL_RST = 24'd50000;
   localparam logic [IVL_W-1:0]   MAX_INTERVAL_RST = 24'd2000000;
   localparam logic [TEMPO_W-1:0] BPM_FLOOR_RST    = 14'd200;
   localparam logic [TEMPO_W-1:0] BPM_CEILING_RST  = 14'd9990;
   localparam logic [TEMPO_W-1:0] TEMPO_RST        = 14'd1200;

endpackage

### rtl/core/tap_tempo_estimator_unit.sv
// tap tempo estimator: tap ring, interval walk, tempo division and clamp
`timescale 1ns / 1ps

// Each request is one tap timestamp in microseconds; each tap gives exactly one
// response with the tempo in tenths of BPM. A tap that arrives more than
// restart_gap_us after the previous one clears the history first. The last
// MAX_TAPS taps sit in a small ring memory; intervals strictly between
// min_interval_us and max_interval_us are summed and counted, and the tempo is
// floor(600000000 * count / sum) clamped to the floor/ceiling registers.
// The block takes one tap at a time and stalls requests while busy.
// A tap passes through these steps: take the request, restart check and ring
// write, an interval walk that reads and examines each stored tap in turn (one
// ring read port), forming the numerator, the restoring divider, which yields
// one quotient bit per cycle, and posting the response. With fewer than two
// taps stored the walk, numerator and divider are skipped; when no interval
// qualifies the numerator and divider are skipped. A response that is still
// stalled holds the block in its last step. Configuration writes are always
// taken and should only happen while idle.
module tap_tempo_estimator_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   // tap requests
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [tte_pkg::TIME_BITS-1:0]           req_tap_time_us,
   // tempo responses
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [tte_pkg::TEMPO_W-1:0]             rsp_tempo_x10,
   output logic                                    rsp_tempo_updated,
   output logic [tte_pkg::USED_W-1:0]              rsp_used_intervals,
   output logic                                    rsp_was_clamped,
   output logic                                    rsp_history_restarted,
   // register writes
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [tte_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  logic [tte_pkg::CSR_DATA_W-1:0]          csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_GAP,
      S_WALK_RD,
      S_WALK_EX,
      S_MUL,
      S_DIV,
      S_FINISH
   } state_type;

   // tap ring, registered read
   logic [tte_pkg::TIME_BITS-1:0] tap_history_mem [tte_pkg::MAX_TAPS];
   logic [tte_pkg::SLOT_W-1:0]    mem_raddr;
   logic [tte_pkg::SLOT_W-1:0]    mem_waddr;
   logic                          mem_we;
   logic [tte_pkg::TIME_BITS-1:0] rd_data_ff;

   // sequencer and datapath registers
   state_type                     state_ff, state_in;
   logic [tte_pkg::TIME_BITS-1:0] now_ff, now_in;
   logic [tte_pkg::TIME_BITS-1:0] prev_ff, prev_in;
   logic [tte_pkg::SLOT_W-1:0]    slot_ff, slot_in;
   logic [tte_pkg::CNT_W-1:0]     stored_ff, stored_in;
   logic [tte_pkg::SLOT_W-1:0]    ptr_ff, ptr_in;
   logic [tte_pkg::CNT_W-1:0]     walk_ff, walk_in;
   logic [tte_pkg::SUM_W-1:0]     sum_ff, sum_in;
   logic [tte_pkg::CNT_W-1:0]     count_ff, count_in;
   logic                          restarted_ff, restarted_in;
   logic [tte_pkg::QUO_W-1:0]     div_q_ff, div_q_in;
   logic [tte_pkg::SUM_W-1:0]     div_rem_ff, div_rem_in;
   logic [tte_pkg::STEP_W-1:0]    div_step_ff, div_step_in;
   logic [tte_pkg::TEMPO_W-1:0]   tempo_now_ff, tempo_now_in;

   // configuration registers
   logic [tte_pkg::IVL_W-1:0]     restart_gap_ff, restart_gap_in;
   logic [tte_pkg::IVL_W-1:0]     min_ivl_ff, min_ivl_in;
   logic [tte_pkg::IVL_W-1:0]     max_ivl_ff, max_ivl_in;
   logic [tte_pkg::TEMPO_W-1:0]   floor_ff, floor_in;
   logic [tte_pkg::TEMPO_W-1:0]   ceiling_ff, ceiling_in;

   // response registers
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [tte_pkg::TEMPO_W-1:0]   rsp_tempo_ff, rsp_tempo_in;
   logic                          rsp_updated_ff, rsp_updated_in;
   logic [tte_pkg::USED_W-1:0]    rsp_used_ff, rsp_used_in;
   logic                          rsp_clamped_ff, rsp_clamped_in;
   logic                          rsp_restarted_ff, rsp_restarted_in;

   // combinational helpers
   logic [tte_pkg::TIME_BITS-1:0] gap;
   logic                          restart;
   logic [tte_pkg::SLOT_W-1:0]    slot_eff;
   logic [tte_pkg::SLOT_W-1:0]    slot_new;
   logic [tte_pkg::CNT_W-1:0]     stored_base;
   logic [tte_pkg::CNT_W-1:0]     stored_new;
   logic [tte_pkg::CNT_W:0]       oldest_wide;
   logic [tte_pkg::TIME_BITS-1:0] dt;
   logic                          dt_ok;
   logic                          walk_last;
   logic [tte_pkg::SUM_W:0]       rem_shift;
   logic [tte_pkg::SUM_W:0]       rem_diff;
   logic                          have_est;
   logic [tte_pkg::TEMPO_W-1:0]   tempo_new;
   logic                          clamp_hit;
   logic                          rsp_load;

   assign req_stall             = reset || (state_ff != S_IDLE);
   assign csr_ready             = 1'b1;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_tempo_x10         = rsp_tempo_ff;
   assign rsp_tempo_updated     = rsp_updated_ff;
   assign rsp_used_intervals    = rsp_used_ff;
   assign rsp_was_clamped       = rsp_clamped_ff;
   assign rsp_history_restarted = rsp_restarted_ff;

   // ring memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tap_history_mem[mem_waddr] <= now_ff;
      end
      rd_data_ff <= tap_history_mem[mem_raddr];
   end

   // restart check and ring bookkeeping for the tap being stored
   always_comb begin
      gap     = now_ff - rd_data_ff;
      restart = (stored_ff != '0) && (gap > tte_pkg::TIME_BITS'(restart_gap_ff));

      slot_eff = restart ? '0 : slot_ff;
      slot_new = (slot_eff == tte_pkg::SLOT_W'(tte_pkg::MAX_TAPS - 1))
               ? '0 : slot_eff + 1'b1;

      stored_base = restart ? '0 : stored_ff;
      stored_new  = (stored_base == tte_pkg::CNT_W'(tte_pkg::MAX_TAPS))
                  ? stored_base : stored_base + 1'b1;

      // oldest stored slot, wrapping around the ring
      if ((tte_pkg::CNT_W + 1)'(slot_new) >= (tte_pkg::CNT_W + 1)'(stored_new)) begin
         oldest_wide = (tte_pkg::CNT_W + 1)'(slot_new) - (tte_pkg::CNT_W + 1)'(stored_new);
      end else begin
         oldest_wide = (tte_pkg::CNT_W + 1)'(slot_new)
                     + (tte_pkg::CNT_W + 1)'(tte_pkg::MAX_TAPS)
                     - (tte_pkg::CNT_W + 1)'(stored_new);
      end
   end

   // interval walk and divider step
   always_comb begin
      dt        = rd_data_ff - prev_ff;
      dt_ok     = (walk_ff != '0)
               && (dt > tte_pkg::TIME_BITS'(min_ivl_ff))
               && (dt < tte_pkg::TIME_BITS'(max_ivl_ff));
      walk_last = ((walk_ff + 1'b1) == stored_ff);

      rem_shift = {div_rem_ff, div_q_ff[tte_pkg::QUO_W-1]};
      rem_diff  = rem_shift - {1'b0, sum_ff};
   end

   // tempo from the quotient, floor checked first
   always_comb begin
      have_est  = (count_ff != '0);
      clamp_hit = 1'b0;
      if (div_q_ff < tte_pkg::QUO_W'(floor_ff)) begin
         tempo_new = floor_ff;
         clamp_hit = 1'b1;
      end else if (div_q_ff > tte_pkg::QUO_W'(ceiling_ff)) begin
         tempo_new = ceiling_ff;
         clamp_hit = 1'b1;
      end else begin
         tempo_new = div_q_ff[tte_pkg::TEMPO_W-1:0];
      end
   end

   // next-state logic
   always_comb begin
      state_in         = state_ff;
      now_in           = now_ff;
      prev_in          = prev_ff;
      slot_in          = slot_ff;
      stored_in        = stored_ff;
      ptr_in           = ptr_ff;
      walk_in          = walk_ff;
      sum_in           = sum_ff;
      count_in         = count_ff;
      restarted_in     = restarted_ff;
      div_q_in         = div_q_ff;
      div_rem_in       = div_rem_ff;
      div_step_in      = div_step_ff;
      tempo_now_in     = tempo_now_ff;
      rsp_tempo_in     = rsp_tempo_ff;
      rsp_updated_in   = rsp_updated_ff;
      rsp_used_in      = rsp_used_ff;
      rsp_clamped_in   = rsp_clamped_ff;
      rsp_restarted_in = rsp_restarted_ff;
      rsp_load         = 1'b0;
      mem_we           = 1'b0;
      mem_waddr        = slot_eff;
      mem_raddr        = ptr_ff;

      restart_gap_in = restart_gap_ff;
      min_ivl_in     = min_ivl_ff;
      max_ivl_in     = max_ivl_ff;
      floor_in       = floor_ff;
      ceiling_in     = ceiling_ff;

      // register writes
      if (csr_valid) begin
         unique case (csr_index)
            tte_pkg::CSR_RESTART_GAP:  restart_gap_in = csr_wdata[tte_pkg::IVL_W-1:0];
            tte_pkg::CSR_MIN_INTERVAL: min_ivl_in     = csr_wdata[tte_pkg::IVL_W-1:0];
            tte_pkg::CSR_MAX_INTERVAL: max_ivl_in     = csr_wdata[tte_pkg::IVL_W-1:0];
            tte_pkg::CSR_BPM_FLOOR:    floor_in       = csr_wdata[tte_pkg::TEMPO_W-1:0];
            tte_pkg::CSR_BPM_CEILING:  ceiling_in     = csr_wdata[tte_pkg::TEMPO_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            // read the newest stored tap for the restart check
            mem_raddr = (slot_ff == '0) ? tte_pkg::SLOT_W'(tte_pkg::MAX_TAPS - 1)
                                        : slot_ff - 1'b1;
            if (req_valid) begin
               now_in   = req_tap_time_us;
               state_in = S_GAP;
            end
         end
         S_GAP: begin
            mem_we       = 1'b1;
            restarted_in = restart;
            slot_in      = slot_new;
            stored_in    = stored_new;
            ptr_in       = oldest_wide[tte_pkg::SLOT_W-1:0];
            walk_in      = '0;
            sum_in       = '0;
            count_in     = '0;
            state_in     = (stored_new >= tte_pkg::CNT_W'(2)) ? S_WALK_RD : S_FINISH;
         end
         S_WALK_RD: begin
            state_in = S_WALK_EX;
         end
         S_WALK_EX: begin
            prev_in = rd_data_ff;
            walk_in = walk_ff + 1'b1;
            ptr_in  = (ptr_ff == tte_pkg::SLOT_W'(tte_pkg::MAX_TAPS - 1))
                    ? '0 : ptr_ff + 1'b1;
            if (dt_ok) begin
               sum_in   = sum_ff + tte_pkg::SUM_W'(dt[tte_pkg::IVL_W-1:0]);
               count_in = count_ff + 1'b1;
            end
            if (walk_last) begin
               state_in = (count_in != '0) ? S_MUL : S_FINISH;
            end else begin
               state_in = S_WALK_RD;
            end
         end
         S_MUL: begin
            div_q_in    = tte_pkg::QUO_W'(tte_pkg::TENTHS_NUMERATOR)
                        * tte_pkg::QUO_W'(count_ff);
            div_rem_in  = '0;
            div_step_in = '0;
            state_in    = S_DIV;
         end
         S_DIV: begin
            // restoring division, one quotient bit per cycle
            if (!rem_diff[tte_pkg::SUM_W]) begin
               div_rem_in = rem_diff[tte_pkg::SUM_W-1:0];
               div_q_in   = {div_q_ff[tte_pkg::QUO_W-2:0], 1'b1};
            end else begin
               div_rem_in = rem_shift[tte_pkg::SUM_W-1:0];
               div_q_in   = {div_q_ff[tte_pkg::QUO_W-2:0], 1'b0};
            end
            div_step_in = div_step_ff + 1'b1;
            if (div_step_ff == tte_pkg::STEP_W'(tte_pkg::QUO_W - 1)) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load         = 1'b1;
               rsp_tempo_in     = have_est ? tempo_new : tempo_now_ff;
               rsp_updated_in   = have_est;
               rsp_clamped_in   = have_est && clamp_hit;
               rsp_restarted_in = restarted_ff;
               rsp_used_in      = (32'(count_ff) > 32'(tte_pkg::USED_MAX))
                                ? tte_pkg::USED_MAX : tte_pkg::USED_W'(count_ff);
               if (have_est) begin
                  tempo_now_in = tempo_new;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         slot_ff        <= '0;
         stored_ff      <= '0;
         tempo_now_ff   <= tte_pkg::TEMPO_RST;
         rsp_valid_ff   <= 1'b0;
         restart_gap_ff <= tte_pkg::RESTART_GAP_RST;
         min_ivl_ff     <= tte_pkg::MIN_INTERVAL_RST;
         max_ivl_ff     <= tte_pkg::MAX_INTERVAL_RST;
         floor_ff       <= tte_pkg::BPM_FLOOR_RST;
         ceiling_ff     <= tte_pkg::BPM_CEILING_RST;
      end else begin
         state_ff       <= state_in;
         slot_ff        <= slot_in;
         stored_ff      <= stored_in;
         tempo_now_ff   <= tempo_now_in;
         rsp_valid_ff   <= rsp_valid_in;
         restart_gap_ff <= restart_gap_in;
         min_ivl_ff     <= min_ivl_in;
         max_ivl_ff     <= max_ivl_in;
         floor_ff       <= floor_in;
         ceiling_ff     <= ceiling_in;
      end
      now_ff           <= now_in;
      prev_ff          <= prev_in;
      ptr_ff           <= ptr_in;
      walk_ff          <= walk_in;
      sum_ff           <= sum_in;
      count_ff         <= count_in;
      restarted_ff     <= restarted_in;
      div_q_ff         <= div_q_in;
      div_rem_ff       <= div_rem_in;
      div_step_ff      <= div_step_in;
      rsp_tempo_ff     <= rsp_tempo_in;
      rsp_updated_ff   <= rsp_updated_in;
      rsp_used_ff      <= rsp_used_in;
      rsp_clamped_ff   <= rsp_clamped_in;
      rsp_restarted_ff <= rsp_restarted_in;
   end

endmodule

### rtl/core/tte_checker.sv
// port-level checks for the tap tempo estimator, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tte_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [tte_pkg::TEMPO_W-1:0]         rsp_tempo_x10,
   input logic                                rsp_tempo_updated,
   input logic [tte_pkg::USED_W-1:0]          rsp_used_intervals,
   input logic                                rsp_was_clamped
);

   logic rsp_plain;    // response without a new estimate
   logic rsp_est;      // response carrying a new estimate
   logic rsp_waiting;  // response offered but stalled

   assign rsp_plain   = rsp_valid && !rsp_tempo_updated;
   assign rsp_est     = rsp_valid && rsp_tempo_updated;
   assign rsp_waiting = rsp_valid && rsp_stall;

   // one tap at a time: busy right after a request is taken
   `TTE_ASSERT(busy_after_req, clock, reset, (!reset && req_valid && !req_stall) |=> req_stall)

   // no estimate means no clamp and no intervals
   `TTE_ASSERT(no_est_clean, clock, reset, rsp_plain |-> (!rsp_was_clamped && rsp_used_intervals == '0))

   // an estimate always rests on at least one interval
   `TTE_ASSERT_MSG(est_has_ivl, clock, reset, rsp_est |-> rsp_used_intervals != '0, "no intervals")

   // a stalled response holds its tempo
   `TTE_ASSERT(rsp_hold, clock, reset, rsp_waiting |=> (rsp_valid && $stable(rsp_tempo_x10)))

endmodule

bind tap_tempo_estimator_unit tte_checker u_tte_checker (.*);
